### hw/rtl/biquad_filter_stereo_core_defines.svh
// assertion macros for the stereo biquad core
// no dependencies; included by the top level only
`ifndef BIQUAD_FILTER_STEREO_CORE_DEFINES_SVH
`define BIQUAD_FILTER_STEREO_CORE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define BQF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define BQF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/bqf_pkg.sv
// shared types and constants of the stereo biquad core
// no dependencies
`timescale 1ns / 1ps

package bqf_pkg;

  // coefficients are signed q3.16
  localparam int COEF_FRAC = 16;
  localparam int COEF_ONE  = 1 << COEF_FRAC;
  localparam int NUM_COEFS = 5;
  localparam int CFG_IDX_W = 3;

  // pcm sample format
  localparam int PCM_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    COEF_FF0 = 3'd0,
    COEF_FF1 = 3'd1,
    COEF_FF2 = 3'd2,
    COEF_FB1 = 3'd3,
    COEF_FB2 = 3'd4
  } coef_idx_e;

endpackage

### hw/rtl/biquad_filter_stereo_core.sv
// stereo biquad filter, transposed direct form ii, one shared multiplier
// depends on bqf_pkg and biquad_filter_stereo_core_defines.svh
`timescale 1ns / 1ps
`include "biquad_filter_stereo_core_defines.svh"

// channel   | direction | handshake                  | payload
// ----------+-----------+----------------------------+-------------------------------
// input     | in        | in_valid_i / in_stall_o    | sample_i, channel_i
// output    | out       | out_valid_o / out_stall_i  | filtered_sample_o, clipped_o
// config    | in        | cfg_we_i (no wait)         | cfg_index_i, cfg_data_i
//
// one word at a time: it is taken in the accept cycle, then 11 sequencer steps run
// on the single COEF_WIDTH x ((STATE_WIDTH+1)/2+1) multiplier that forms all five
// products, each feedback product taking two passes (low and high half of y)
// in_stall_o is high while the sequencer runs; the final step waits while a
// previous result word is still held and stalled at the output register
// reset clears state, coefficients (ff0 = 1.0, others 0) and both delay sets

module biquad_filter_stereo_core #(
  parameter int COEF_WIDTH  = 20,
  parameter int STATE_WIDTH = 40
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // input words
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [bqf_pkg::PCM_W-1:0]      sample_i,
  input  logic                                  channel_i,
  // result words
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [bqf_pkg::PCM_W-1:0]      filtered_sample_o,
  output logic                                  clipped_o,
  // coefficient writes
  input  logic                                  cfg_we_i,
  input  logic [bqf_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [COEF_WIDTH-1:0]                 cfg_data_i
);

  // widths derived from the parameters
  localparam int CW = COEF_WIDTH;
  localparam int SW = STATE_WIDTH;
  localparam int LH = (SW + 1) / 2;       // low half of y, unsigned
  localparam int HW = SW - LH;            // high half of y, signed
  localparam int OW = LH + 1;             // multiplier operand width
  localparam int PW = CW + OW;            // product width
  localparam int AW = CW + SW + 2;        // accumulator width
  localparam int XW = bqf_pkg::PCM_W;

  localparam logic signed [AW-1:0] ST_MAX = {{(AW-SW+1){1'b0}}, {(SW-1){1'b1}}};
  localparam logic signed [AW-1:0] ST_MIN = ~ST_MAX;
  localparam logic signed [AW-1:0] HALF   = AW'(1) <<< (bqf_pkg::COEF_FRAC - 1);
  localparam logic [SW-1:0]        YM_LIM = SW'(33'h1_0000_0000);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MY,    // acc = ff0*x + z1
    ST_SY,    // y = sat(acc)
    ST_F1L,   // acc = fb1*y_lo
    ST_F1H,   // acc += fb1*y_hi << LH
    ST_R1,    // r = sat(round(acc)), output scaling
    ST_Z1,    // acc = ff1*x - r + z2
    ST_F2L,   // z1 = sat(acc), acc = fb2*y_lo
    ST_F2H,   // acc += fb2*y_hi << LH
    ST_R2,    // r = sat(round(acc))
    ST_Z2,    // acc = ff2*x - r
    ST_DONE   // z2 = sat(acc), load result word
  } state_e;

  state_e state_q, state_d;

  logic                    out_valid_q;
  logic signed [CW-1:0]    coef_q [bqf_pkg::NUM_COEFS];
  logic signed [SW-1:0]    z1_q [2];
  logic signed [SW-1:0]    z2_q [2];

  logic signed [XW-1:0]    x_q;
  logic                    ch_q;
  logic signed [AW-1:0]    acc_q, acc_d;
  logic signed [SW-1:0]    y_q;
  logic signed [SW-1:0]    r_q;
  logic signed [XW-1:0]    res_q, res_d;
  logic                    clip_q, clip_d;
  logic signed [XW-1:0]    out_sample_q;
  logic                    out_clip_q;

  // shared multiplier
  bqf_pkg::coef_idx_e      coef_sel;
  logic signed [CW-1:0]    mul_a;
  logic signed [OW-1:0]    mul_b;
  logic signed [PW-1:0]    prod;
  logic signed [AW-1:0]    prod_x;
  logic signed [AW-1:0]    z1_x, z2_x, r_x;
  logic signed [AW-1:0]    rnd;
  logic signed [OW-1:0]    x_op, ylo_op, yhi_op;

  // output scaling by 32767/32768
  logic [SW-1:0]           ym;
  logic [47:0]             ym48;
  logic [47:0]             scaled;
  logic [16:0]             mag, mag_lim;
  logic [16:0]             res17;

  logic                    in_fire;
  logic                    done_fire;
  logic                    cfg_hit;

  function automatic logic signed [SW-1:0] sat_st(input logic signed [AW-1:0] v);
    logic signed [SW-1:0] r;
    if (v > ST_MAX) begin
      r = ST_MAX[SW-1:0];
    end else if (v < ST_MIN) begin
      r = ST_MIN[SW-1:0];
    end else begin
      r = v[SW-1:0];
    end
    return r;
  endfunction

  assign in_stall_o        = (state_q != ST_IDLE);
  assign in_fire           = in_valid_i && !in_stall_o;
  assign done_fire         = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);
  assign cfg_hit           = cfg_we_i && (cfg_index_i < 3'(bqf_pkg::NUM_COEFS));
  assign out_valid_o       = out_valid_q;
  assign filtered_sample_o = out_sample_q;
  assign clipped_o         = out_clip_q;

  // operand formats for the multiplier
  assign x_op   = $signed({{(OW-XW){x_q[XW-1]}}, x_q});
  assign ylo_op = $signed({1'b0, y_q[LH-1:0]});
  assign yhi_op = $signed({{(OW-HW){y_q[SW-1]}}, y_q[SW-1:LH]});

  always_comb begin
    coef_sel = bqf_pkg::COEF_FF0;
    mul_b    = x_op;
    case (state_q)
      ST_MY: begin
        coef_sel = bqf_pkg::COEF_FF0;
        mul_b    = x_op;
      end
      ST_F1L: begin
        coef_sel = bqf_pkg::COEF_FB1;
        mul_b    = ylo_op;
      end
      ST_F1H: begin
        coef_sel = bqf_pkg::COEF_FB1;
        mul_b    = yhi_op;
      end
      ST_Z1: begin
        coef_sel = bqf_pkg::COEF_FF1;
        mul_b    = x_op;
      end
      ST_F2L: begin
        coef_sel = bqf_pkg::COEF_FB2;
        mul_b    = ylo_op;
      end
      ST_F2H: begin
        coef_sel = bqf_pkg::COEF_FB2;
        mul_b    = yhi_op;
      end
      ST_Z2: begin
        coef_sel = bqf_pkg::COEF_FF2;
        mul_b    = x_op;
      end
      default: begin
        coef_sel = bqf_pkg::COEF_FF0;
        mul_b    = x_op;
      end
    endcase
  end

  assign mul_a  = coef_q[coef_sel];
  assign prod   = mul_a * mul_b;
  assign prod_x = $signed({{(AW-PW){prod[PW-1]}}, prod});
  assign z1_x   = $signed({{(AW-SW){z1_q[ch_q][SW-1]}}, z1_q[ch_q]});
  assign z2_x   = $signed({{(AW-SW){z2_q[ch_q][SW-1]}}, z2_q[ch_q]});
  assign r_x    = $signed({{(AW-SW){r_q[SW-1]}}, r_q});

  // round half away from zero, drop the coefficient fraction bits
  assign rnd = (acc_q + (acc_q[AW-1] ? (HALF - AW'(1)) : HALF)) >>> bqf_pkg::COEF_FRAC;

  always_comb begin
    acc_d = acc_q;
    case (state_q)
      ST_MY:           acc_d = prod_x + z1_x;
      ST_F1L, ST_F2L:  acc_d = prod_x;
      ST_F1H, ST_F2H:  acc_d = acc_q + (prod_x <<< LH);
      ST_Z1:           acc_d = prod_x - r_x + z2_x;
      ST_Z2:           acc_d = prod_x - r_x;
      default:         acc_d = acc_q;
    endcase
  end

  // out = round_half_away(|y| * 32767 / 2^31), clamped; 32767*m as a shift and subtract
  always_comb begin
    ym      = y_q[SW-1] ? SW'(-y_q) : y_q;
    ym48    = 48'(ym[32:0]);
    scaled  = (ym48 << 15) - ym48 + 48'h0000_4000_0000;
    mag     = scaled[47:31];
    clip_d  = 1'b0;
    mag_lim = mag;
    if (ym > YM_LIM) begin
      clip_d  = 1'b1;
      mag_lim = y_q[SW-1] ? 17'd32768 : 17'd32767;
    end else if (y_q[SW-1] && (mag > 17'd32768)) begin
      clip_d  = 1'b1;
      mag_lim = 17'd32768;
    end else if (!y_q[SW-1] && (mag > 17'd32767)) begin
      clip_d  = 1'b1;
      mag_lim = 17'd32767;
    end
    res17 = y_q[SW-1] ? (~mag_lim + 17'd1) : mag_lim;
    res_d = $signed(res17[XW-1:0]);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_fire) begin
        state_d = ST_MY;
      end
      ST_MY:   state_d = ST_SY;
      ST_SY:   state_d = ST_F1L;
      ST_F1L:  state_d = ST_F1H;
      ST_F1H:  state_d = ST_R1;
      ST_R1:   state_d = ST_Z1;
      ST_Z1:   state_d = ST_F2L;
      ST_F2L:  state_d = ST_F2H;
      ST_F2H:  state_d = ST_R2;
      ST_R2:   state_d = ST_Z2;
      ST_Z2:   state_d = ST_DONE;
      ST_DONE: if (done_fire) begin
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control state, coefficients and delay lines
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      for (int i = 0; i < bqf_pkg::NUM_COEFS; i++) begin
        coef_q[i] <= '0;
      end
      coef_q[bqf_pkg::COEF_FF0] <= CW'(bqf_pkg::COEF_ONE);
      for (int i = 0; i < 2; i++) begin
        z1_q[i] <= '0;
        z2_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == ST_F2L) begin
        z1_q[ch_q] <= sat_st(acc_q);
      end
      if (done_fire) begin
        z2_q[ch_q]  <= sat_st(acc_q);
        out_valid_q <= 1'b1;
      end
      // any coefficient write clears both channels' state
      if (cfg_hit) begin
        coef_q[cfg_index_i] <= cfg_data_i;
        for (int i = 0; i < 2; i++) begin
          z1_q[i] <= '0;
          z2_q[i] <= '0;
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (in_fire) begin
      x_q  <= sample_i;
      ch_q <= channel_i;
    end
    if (state_q == ST_SY) begin
      y_q <= sat_st(acc_q);
    end
    if (state_q == ST_R1) begin
      r_q    <= sat_st(rnd);
      res_q  <= res_d;
      clip_q <= clip_d;
    end
    if (state_q == ST_R2) begin
      r_q <= sat_st(rnd);
    end
    if (done_fire) begin
      out_sample_q <= res_q;
      out_clip_q   <= clip_q;
    end
  end

  // checks
  `BQF_ASSERT_NEXT(a_accept_starts_seq, clk_i, rst_ni, in_valid_i && !in_stall_o, state_q == ST_MY, "accepted word did not start the sequencer")
  `BQF_ASSERT_NOW(a_valid_from_done, clk_i, rst_ni, $rose(out_valid_q), $past(state_q) == ST_DONE, "result word raised outside the final step")
  `BQF_ASSERT_NOW(a_clip_at_rail, clk_i, rst_ni, out_valid_q && out_clip_q, out_sample_q == 16'sh7fff || out_sample_q == -16'sh8000, "clip flag without a saturated sample")
  `BQF_ASSERT_NEXT(a_cfg_clears, clk_i, rst_ni, cfg_hit, z1_q[0] == '0 && z1_q[1] == '0 && z2_q[0] == '0 && z2_q[1] == '0, "coefficient write left filter state")

endmodule

### tb/tb.sv
// self-checking bench for the stereo biquad core: directed and random words,
// a built-in fixed point filter predictor, random idling and backpressure
// depends on bqf_pkg and the biquad_filter_stereo_core rtl
`timescale 1ns / 1ps

module tb;
  import bqf_pkg::*;

  localparam int COEF_W      = 20;
  localparam int STATE_W     = 40;
  localparam int IDX_TOP     = (1 << CFG_IDX_W) - 1;
  // leave a margin after the last result for the sequencer to settle
  localparam int DRAIN_CYCLES = 16;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_LIMIT  = 20000;
  localparam int MAX_PRINTS   = 30;

  localparam logic signed [COEF_W-1:0] COEF_MAX = 20'sh7ffff;
  localparam logic signed [COEF_W-1:0] COEF_MIN = 20'sh80000;
  localparam logic signed [PCM_W-1:0]  PCM_MAX  = 16'sh7fff;
  localparam logic signed [PCM_W-1:0]  PCM_MIN  = 16'sh8000;

  // one expected result word
  typedef struct packed {
    logic signed [PCM_W-1:0] pcm;
    logic                    clip;
  } pcm_result_t;

  logic                        clk_i;
  logic                        rst_ni      = 1'b0;
  logic                        in_valid_i  = 1'b0;
  logic                        in_stall_o;
  logic signed [PCM_W-1:0]     sample_i    = '0;
  logic                        channel_i   = 1'b0;
  logic                        out_valid_o;
  logic                        out_stall_i = 1'b0;
  logic signed [PCM_W-1:0]     filtered_sample_o;
  logic                        clipped_o;
  logic                        cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]        cfg_index_i = '0;
  logic [COEF_W-1:0]           cfg_data_i  = '0;

  biquad_filter_stereo_core #(
    .COEF_WIDTH (COEF_W),
    .STATE_WIDTH(STATE_W)
  ) DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .sample_i         (sample_i),
    .channel_i        (channel_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .filtered_sample_o(filtered_sample_o),
    .clipped_o        (clipped_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  // predictor state: coefficients plus one delay pair per channel
  logic signed [COEF_W-1:0]  coef_reg [NUM_COEFS];
  logic signed [STATE_W-1:0] delay1   [2];
  logic signed [STATE_W-1:0] delay2   [2];

  // filtered words still owed by the block, oldest first
  pcm_result_t pending_pcm[$];

  int  errors      = 0;
  int  words_sent  = 0;
  int  results_ok  = 0;
  int  clip_count  = 0;
  int  cfg_writes  = 0;
  bit  tx_quiet    = 1'b0;   // sender never idles when set
  bit  rx_quiet    = 1'b0;   // receiver stalls only for a requested hold when set
  bit  hold_tag    = 1'b0;   // toggled to ask for one long receiver hold
  bit  hold_seen   = 1'b0;
  int  hold_left   = 0;
  int  stall_left  = 0;

  // 2 ns clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // hard limit far beyond the slowest legal run
  initial begin
    #2000000;
    $display("timeout: %0d words sent, %0d results seen", words_sent, results_ok);
    $display("status: fail");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    if (errors < MAX_PRINTS) $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // saturate to the width of a delay register
  function automatic longint clamp_state(input longint v);
    longint hi, lo;
    hi = (longint'(1) <<< (STATE_W - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // c * y with 16 fraction bits dropped, rounded half away from zero, saturated
  function automatic longint scaled_feedback(input longint c, input longint y);
    bit     neg;
    longint uc, uy, lim, mag;
    neg = (c < 0) != (y < 0);
    uc  = (c < 0) ? -c : c;
    uy  = (y < 0) ? -y : y;
    lim = neg ? (longint'(1) <<< (STATE_W - 1)) : (longint'(1) <<< (STATE_W - 1)) - 1;
    // |c| <= 2^19 and |y| <= 2^39, so the product fits in 64 bits
    mag = (uc * uy + (longint'(1) <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
    if (mag > lim) mag = lim;
    return neg ? -mag : mag;
  endfunction

  // one sample through the filter of its channel; updates that channel's delays
  function automatic pcm_result_t filter_step(input logic signed [PCM_W-1:0] s,
                                              input logic ch);
    longint      x, y, z1, z2, ym, m;
    pcm_result_t r;
    x  = longint'(s);
    y  = clamp_state(longint'(coef_reg[COEF_FF0]) * x + longint'(delay1[ch]));
    z1 = clamp_state(longint'(coef_reg[COEF_FF1]) * x
                     - scaled_feedback(longint'(coef_reg[COEF_FB1]), y)
                     + longint'(delay2[ch]));
    z2 = clamp_state(longint'(coef_reg[COEF_FF2]) * x
                     - scaled_feedback(longint'(coef_reg[COEF_FB2]), y));
    delay1[ch] = z1[STATE_W-1:0];
    delay2[ch] = z2[STATE_W-1:0];
    // scale by 32767 / 32768 back to pcm units
    ym = (y < 0) ? -y : y;
    if (ym > (longint'(1) <<< 32)) m = 40000;
    else m = (ym * 32767 + (longint'(1) <<< 30)) >>> 31;
    r.clip = 1'b0;
    if (y < 0) begin
      if (m > 32768) begin
        m = 32768;
        r.clip = 1'b1;
      end
      r.pcm = PCM_W'(-m);
    end else begin
      if (m > 32767) begin
        m = 32767;
        r.clip = 1'b1;
      end
      r.pcm = PCM_W'(m);
    end
    return r;
  endfunction

  task automatic clear_delays();
    for (int i = 0; i < 2; i++) begin
      delay1[i] = '0;
      delay2[i] = '0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // sender idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic signed [PCM_W-1:0] pick_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return PCM_MAX;
    if (r < 6) return PCM_MIN;
    if (r < 8) return '0;
    if (r < 10) return ($urandom_range(0, 1) != 0) ? 16'sd1 : -16'sd1;
    return PCM_W'($urandom);
  endfunction

  // wide: any 20-bit pattern; otherwise roughly within +-1.5
  function automatic logic [COEF_W-1:0] pick_coef(input bit wide);
    if (wide) return COEF_W'($urandom);
    return COEF_W'(int'($urandom_range(0, 196607)) - 98304);
  endfunction

  // offer one word and wait for it to be taken; valid stays high for the next
  // word unless a gap lowers it
  task automatic send_word(input logic signed [PCM_W-1:0] s, input logic ch);
    int gap;
    gap = tx_quiet ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= s;
    channel_i  <= ch;
    do @(posedge clk_i); while (in_stall_o);
    pending_pcm.push_back(filter_step(s, ch));
    words_sent++;
  endtask

  // drop valid and let every owed result come out, then let the block settle
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_pcm.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // one register write; write enable is left high for back to back writes
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_writes++;
    // indexes past the last coefficient are ignored and keep the state
    if (idx < NUM_COEFS) begin
      coef_reg[idx] = val;
      clear_delays();
    end
  endtask

  task automatic load_filter(input logic [COEF_W-1:0] b0, input logic [COEF_W-1:0] b1,
                             input logic [COEF_W-1:0] b2, input logic [COEF_W-1:0] a1,
                             input logic [COEF_W-1:0] a2);
    wait_idle();
    cfg_write(COEF_FF0, b0);
    cfg_write(COEF_FF1, b1);
    cfg_write(COEF_FF2, b2);
    cfg_write(COEF_FB1, a1);
    cfg_write(COEF_FB2, a2);
    cfg_we_i <= 1'b0;
  endtask

  // receiver stalls: random runs, a long hold on request, or none at all
  always @(posedge clk_i) begin
    if (hold_tag != hold_seen) begin
      hold_seen = hold_tag;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else if (rx_quiet) begin
      out_stall_i <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else begin
      automatic int r = $urandom_range(0, 99);
      if (r < 70) begin
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= 1'b1;
        stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(15, 50);
      end
    end
  end

  // result checker: each accepted word against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_pcm.size() == 0) begin
        report_mismatch($sformatf("result word %0d / clip %0b with nothing pending",
                                  filtered_sample_o, clipped_o));
      end else begin
        automatic pcm_result_t want = pending_pcm.pop_front();
        if (filtered_sample_o !== want.pcm)
          report_mismatch($sformatf("filtered_sample got %0d want %0d (result %0d)",
                                    filtered_sample_o, want.pcm, results_ok));
        if (clipped_o !== want.clip)
          report_mismatch($sformatf("clipped got %b want %b (result %0d)",
                                    clipped_o, want.clip, results_ok));
        if (want.clip) clip_count++;
        results_ok++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset coefficients give a plain 32767/32768 gain on both channels
  task automatic test_unity_gain();
    logic signed [PCM_W-1:0] vals [8];
    vals = '{16'sd0, PCM_MAX, PCM_MIN, 16'sd1, -16'sd1, 16'sd16384, -16'sd16385,
             16'sd12345};
    for (int i = 0; i < 8; i++) send_word(vals[i], i[0]);
  endtask

  // all coefficients at the top, then the bottom, of their range: state and
  // output saturation, clip flag on both signs
  task automatic test_coef_extremes();
    load_filter(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
    send_word(PCM_MAX, 1'b0);
    send_word(PCM_MIN, 1'b1);
    send_word(PCM_MAX, 1'b0);
    send_word(16'sd0, 1'b1);
    load_filter(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
    send_word(PCM_MAX, 1'b1);
    send_word(PCM_MIN, 1'b0);
    send_word(PCM_MIN, 1'b1);
    send_word(16'sd0, 1'b0);
    // gain of about 8 with no feedback: clips on ordinary samples
    load_filter(COEF_MAX, '0, '0, '0, '0);
    send_word(16'sd5000, 1'b0);
    send_word(-16'sd5000, 1'b1);
  endtask

  // writes to unused indexes must neither change a coefficient nor clear state
  task automatic test_ignored_index();
    load_filter(COEF_W'(40000), COEF_W'(30000), COEF_W'(-20000), COEF_W'(-60000),
                COEF_W'(25000));
    send_word(16'sd20000, 1'b0);
    send_word(-16'sd12000, 1'b1);
    wait_idle();
    for (int i = NUM_COEFS; i <= IDX_TOP; i++)
      cfg_write(CFG_IDX_W'(i), pick_coef(1'b1));
    cfg_we_i <= 1'b0;
    send_word(16'sd7, 1'b0);
    send_word(16'sd0, 1'b1);
    send_word(PCM_MIN, 1'b0);
  endtask

  // several filters, stable ones and random ones, interleaved channels
  task automatic test_random_filters();
    for (int set = 0; set < 7; set++) begin
      case (set)
        0: load_filter(COEF_W'(4424), COEF_W'(8848), COEF_W'(4424), COEF_W'(-74899),
                       COEF_W'(27054));
        1: load_filter(COEF_W'(52429), COEF_W'(-104858), COEF_W'(52429),
                       COEF_W'(-96000), COEF_W'(35000));
        2: load_filter(COEF_W'(70000), COEF_W'(-120000), COEF_W'(55000),
                       COEF_W'(-120000), COEF_W'(60000));
        3, 4: load_filter(pick_coef(1'b0), pick_coef(1'b0), pick_coef(1'b0),
                          pick_coef(1'b0), pick_coef(1'b0));
        default: load_filter(pick_coef(1'b1), pick_coef(1'b1), pick_coef(1'b1),
                             pick_coef(1'b1), pick_coef(1'b1));
      endcase
      // occasional stray write to an unused index mid-set
      for (int i = 0; i < 105; i++) begin
        if (i == 50 && set[0]) begin
          wait_idle();
          cfg_write(CFG_IDX_W'($urandom_range(NUM_COEFS, IDX_TOP)), pick_coef(1'b1));
          cfg_we_i <= 1'b0;
        end
        send_word(pick_sample(), 1'($urandom));
      end
    end
  endtask

  // receiver holds off for a long stretch while words keep coming, so the
  // output register fills and the input stalls
  task automatic test_output_hold();
    load_filter(COEF_W'(4424), COEF_W'(8848), COEF_W'(4424), COEF_W'(-74899),
                COEF_W'(27054));
    tx_quiet = 1'b1;
    hold_tag <= ~hold_tag;
    for (int i = 0; i < 60; i++) send_word(pick_sample(), 1'($urandom));
    tx_quiet = 1'b0;
  endtask

  // sender pauses until all results are out, then goes on; part of it runs
  // with neither side idling
  task automatic test_sender_pause();
    load_filter(pick_coef(1'b0), pick_coef(1'b0), pick_coef(1'b0), pick_coef(1'b0),
                pick_coef(1'b0));
    for (int i = 0; i < 30; i++) send_word(pick_sample(), 1'($urandom));
    wait_idle();
    for (int i = 0; i < 30; i++) send_word(pick_sample(), 1'($urandom));
    rx_quiet <= 1'b1;
    tx_quiet = 1'b1;
    for (int i = 0; i < 40; i++) send_word(pick_sample(), 1'($urandom));
    tx_quiet = 1'b0;
    rx_quiet <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int waited;
    coef_reg = '{default: '0};
    coef_reg[COEF_FF0] = COEF_W'(COEF_ONE);
    clear_delays();

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_unity_gain();
    test_coef_extremes();
    test_ignored_index();
    test_random_filters();
    test_output_hold();
    test_sender_pause();

    // drain with a limit, then give the block its latency once more
    in_valid_i <= 1'b0;
    waited = 0;
    while (pending_pcm.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_pcm.size() != 0)
      report_mismatch($sformatf("%0d result words never arrived", pending_pcm.size()));

    $display("covered %0d sample words on both channels under %0d register writes",
             words_sent, cfg_writes);
    $display("checked %0d result words, %0d of them clipped, %0d mismatches",
             results_ok, clip_count, errors);
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
